@@ rtl/core/wrbm_pkg.sv @@
// wrbm_pkg: shared types, score constants and case-folding helpers for
// the weighted rule best match block. No dependencies.

package wrbm_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int SCORE_W = 17;
  localparam logic signed [SCORE_W-1:0] SCORE_TYPE     = 17'sd100;
  localparam logic signed [SCORE_W-1:0] SCORE_OPERATOR = 17'sd50;
  localparam logic signed [SCORE_W-1:0] SCORE_PREFIX   = 17'sd25;
  localparam logic signed [SCORE_W-1:0] SCORE_NONE     = -17'sd1;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         rule_slot;
    logic [31:0]        type_code;
    logic [23:0]        operator_code;
    logic [23:0]        call_prefix;
    logic signed [15:0] rule_priority;
  } in_item_t;

  typedef struct packed {
    logic        match_found;
    logic [5:0]  match_index;
    logic [15:0] match_score;
  } out_item_t;

  typedef struct packed {
    logic               type_code_set;
    logic [31:0]        type_code;
    logic [23:0]        operator_code;
    logic [23:0]        call_prefix;
    logic signed [15:0] rule_priority;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic write_rule;
    logic load_query;
    logic issue_read;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_empty;
    logic scan_last;
  } ctrl_status_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7a) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [31:0] fold4(input logic [31:0] c);
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      r[8*i +: 8] = fold_byte(c[8*i +: 8]);
    end
    return r;
  endfunction

  function automatic logic [23:0] fold3(input logic [23:0] c);
    logic [23:0] r;
    for (int i = 0; i < 3; i++) begin
      r[8*i +: 8] = fold_byte(c[8*i +: 8]);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/wrbm_ctrl.sv @@
// wrbm_ctrl: sequencer for rule writes and query scans.
// Depends on wrbm_pkg for the state type and command/status structs.

module wrbm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  req_is_query,
  input  wrbm_pkg::ctrl_status_t status,
  output wrbm_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  wrbm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrbm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrbm_pkg::ST_IDLE: begin
        if (start && req_is_query) begin
          state_nxt = wrbm_pkg::ST_SCAN;
        end
      end
      wrbm_pkg::ST_SCAN: begin
        if (status.scan_empty) begin
          state_nxt = wrbm_pkg::ST_FINISH;
        end else if (status.scan_last) begin
          state_nxt = wrbm_pkg::ST_DRAIN;
        end
      end
      wrbm_pkg::ST_DRAIN:  state_nxt = wrbm_pkg::ST_FINISH;
      wrbm_pkg::ST_FINISH: state_nxt = wrbm_pkg::ST_IDLE;
      default:             state_nxt = wrbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      wrbm_pkg::ST_IDLE: begin
        busy           = 1'b0;
        cmd.write_rule = start && !req_is_query;
        cmd.load_query = start && req_is_query;
      end
      wrbm_pkg::ST_SCAN: begin
        cmd.issue_read = !status.scan_empty;
      end
      wrbm_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      wrbm_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/wrbm_dp.sv @@
// wrbm_dp: rule memory, scan address counter, per-rule scoring and
// best-match tracking. Depends on wrbm_pkg.

module wrbm_dp #(
  parameter int MAX_RULES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wrbm_pkg::in_item_t     in_data,
  input  logic                   cfg_we,
  input  logic [6:0]             cfg_wdata,
  input  wrbm_pkg::ctrl_cmd_t    cmd,
  output wrbm_pkg::ctrl_status_t status,
  output logic                   out_valid,
  output wrbm_pkg::out_item_t    out_data
);

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam int SW    = wrbm_pkg::SCORE_W;

  wrbm_pkg::rule_t rule_mem [MAX_RULES];

  logic [6:0]          rule_count_r;
  logic [CNT_W-1:0]    scan_n_r;
  logic [CNT_W-1:0]    addr_r;
  logic [31:0]         q_type_r;
  logic [23:0]         q_oper_r;
  logic [23:0]         q_pref_r;
  wrbm_pkg::rule_t     rd_rule_r;
  logic                rd_valid_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic signed [SW-1:0] best_score_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic                best_found_r;
  logic                out_valid_r;
  wrbm_pkg::out_item_t out_data_r;

  logic [CNT_W-1:0]     scan_n_nxt;
  logic                 slot_ok;
  logic                 type_ok;
  logic signed [SW-1:0] rule_score;

  // scan length is the register value capped at the table size
  always_comb begin
    if (CMP_W'(rule_count_r) > CMP_W'(MAX_RULES)) begin
      scan_n_nxt = CNT_W'(MAX_RULES);
    end else begin
      scan_n_nxt = CNT_W'(rule_count_r);
    end
    slot_ok = 32'(in_data.rule_slot) < 32'(MAX_RULES);
  end

  always_ff @(posedge clk) begin
    if (cmd.write_rule && slot_ok) begin
      rule_mem[IDX_W'(in_data.rule_slot)] <= '{
        type_code_set: 1'b0,
        type_code:     in_data.type_code,
        operator_code: in_data.operator_code,
        call_prefix:   in_data.call_prefix,
        rule_priority: in_data.rule_priority
      };
    end
    if (cmd.issue_read) begin
      rd_rule_r <= rule_mem[addr_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
    end else if (cfg_we) begin
      rule_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_type_r <= wrbm_pkg::fold4(in_data.type_code);
      q_oper_r <= wrbm_pkg::fold3(in_data.operator_code);
      q_pref_r <= wrbm_pkg::fold3(in_data.call_prefix);
      scan_n_r <= scan_n_nxt;
    end
    if (cmd.load_query) begin
      addr_r <= '0;
    end else if (cmd.issue_read) begin
      addr_r <= addr_r + 1'b1;
    end
    if (cmd.issue_read) begin
      rd_idx_r <= addr_r[IDX_W-1:0];
    end
  end

  always_comb begin
    status.scan_empty = (scan_n_r == '0);
    status.scan_last  = (addr_r == scan_n_r - 1'b1);
  end

  // score of the rule read last cycle
  always_comb begin
    type_ok    = (rd_rule_r.type_code == '0) ||
                 (wrbm_pkg::fold4(rd_rule_r.type_code) == q_type_r);
    rule_score = SW'(rd_rule_r.rule_priority);
    if (rd_rule_r.type_code != '0) begin
      rule_score = rule_score + wrbm_pkg::SCORE_TYPE;
    end
    if (rd_rule_r.operator_code != '0 &&
        wrbm_pkg::fold3(rd_rule_r.operator_code) == q_oper_r) begin
      rule_score = rule_score + wrbm_pkg::SCORE_OPERATOR;
    end
    if (rd_rule_r.call_prefix != '0 &&
        wrbm_pkg::fold3(rd_rule_r.call_prefix) == q_pref_r) begin
      rule_score = rule_score + wrbm_pkg::SCORE_PREFIX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= cmd.issue_read;
      out_valid_r <= cmd.finish;
    end
  end

  // strict greater-than keeps the lower slot on a tie
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      best_score_r <= wrbm_pkg::SCORE_NONE;
      best_idx_r   <= '0;
      best_found_r <= 1'b0;
    end else if (rd_valid_r && type_ok && rule_score > best_score_r) begin
      best_score_r <= rule_score;
      best_idx_r   <= rd_idx_r;
      best_found_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_data_r.match_found <= best_found_r;
      out_data_r.match_index <= best_found_r ? 6'(best_idx_r) : 6'd0;
      out_data_r.match_score <= best_found_r ? best_score_r[15:0] : 16'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/weighted_rule_best_match.sv @@
// weighted_rule_best_match: top level joining the sequencer and the datapath.
// Depends on wrbm_pkg, wrbm_ctrl and wrbm_dp.
//
// A rule write (req_type 0) is taken while idle and busy never rises for it.
// A query (req_type 1) reads one rule per cycle from a single-port rule
// memory, so it holds busy while it scans min(rule_count, MAX_RULES) rules
// and finishes; the result then appears on out_data with out_valid for
// exactly one cycle, at the same time as busy falls. The receiver cannot
// stall, so the result must be captured in that cycle; a new start may be
// given in that same cycle. Table entries hold no value until written and
// must be written before a query scans them. rule_count must be written
// through cfg_we/cfg_wdata only while busy is low; not enforced by the block.

module weighted_rule_best_match #(
  parameter int MAX_RULES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wrbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  output wrbm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);

  wrbm_pkg::ctrl_cmd_t    cmd;
  wrbm_pkg::ctrl_status_t status;

  wrbm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .req_is_query (in_data.req_type == wrbm_pkg::REQ_QUERY),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy)
  );

  wrbm_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_result_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_write_no_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.req_type == wrbm_pkg::REQ_WRITE) |=> !busy)
    else $error("rule write raised busy");

  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_no_match_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.match_found) |->
      (out_data.match_index == '0 && out_data.match_score == '0))
    else $error("no-match result carries non-zero fields");

endmodule
